// File: rtl/bfg_pkg.sv
package bfg_pkg;

	// Field and register widths fixed by the interface.
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Row counter holds positions up to frame_height + 1 (flush row).
	localparam int ROW_W = FH_W + 1;

	// Sum of nine 8-bit reds fits in 12 bits.
	localparam int SUM_W = 12;

	// floor(x / 9) == (x * 7282) >> 16 for every x below 2296.
	localparam int               RECIP_W    = 13;
	localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
	localparam int               DIV9_SHIFT = 16;
	localparam int               PROD_W     = SUM_W + RECIP_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// Register values after reset.
	localparam int              RST_WIDTH  = 640;
	localparam logic [FH_W-1:0] RST_HEIGHT = 13'd480;

	typedef logic [PIX_W-1:0] rgb_t;

	// What the position of an item says about the pixel it retires.
	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} pos_flags_t;

endpackage

// File: rtl/bfg_ram.sv
module bfg_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/bfg_pos.sv
module bfg_pos import bfg_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 adv,
	output logic [CW-1:0]        col,
	output pos_flags_t           flags
);

	localparam int RST_W_EFF = (MAX_WIDTH < RST_WIDTH) ? MAX_WIDTH : RST_WIDTH;

	logic [WW-1:0]    eff_w_q;
	logic [FH_W-1:0]  eff_h_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [FW_W-1:0]  fw;
	logic [FH_W-1:0]  fh;
	logic [WW-1:0]    new_w;
	logic [FH_W-1:0]  new_h;
	logic [WW-1:0]    c_x;
	logic [WW-1:0]    c_p1;
	logic [ROW_W-1:0] h_x;
	logic [ROW_W-1:0] h_p1;
	logic [ROW_W-1:0] r_p1;

	// Effective width and height are clamped once, when written.
	always_comb begin
		fw = cfg_data[FW_W-1:0];
		fh = cfg_data[FH_W-1:0];
		if (fw == '0) begin
			new_w = WW'(1);
		end else if (32'(fw) > 32'(MAX_WIDTH)) begin
			new_w = WW'(MAX_WIDTH);
		end else begin
			new_w = WW'(fw);
		end
		new_h = (fh == '0) ? FH_W'(1) : fh;
	end

	// The retired pixel is interior when its row lies strictly between the
	// first and last rows and its column is at least one; its column can
	// never be the last, because a beat in column zero retires the last one.
	always_comb begin
		c_x  = WW'(col_q);
		c_p1 = c_x + WW'(1);
		h_x  = ROW_W'(eff_h_q);
		h_p1 = h_x + ROW_W'(1);
		r_p1 = row_q + ROW_W'(1);

		flags.emit = ((col_q != '0) && (row_q != '0) && (row_q <= h_x)) ||
		             ((col_q == '0) && (row_q >= ROW_W'(2)));
		flags.interior = (row_q >= ROW_W'(2)) && (row_q < h_x) &&
		                 (col_q >= CW'(2));
		flags.last = (col_q == '0) && (row_q == h_p1);
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(RST_W_EFF);
			eff_h_q <= RST_HEIGHT;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					eff_w_q <= new_w;
					col_q   <= '0;
					row_q   <= '0;
				end
				CFG_FRAME_HEIGHT: begin
					eff_h_q <= new_h;
					col_q   <= '0;
					row_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			if (flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_p1 == eff_w_q) begin
				col_q <= '0;
				row_q <= r_p1;
			end else begin
				col_q <= CW'(c_p1);
			end
		end
	end

endmodule

// File: rtl/bfg_win.sv
module bfg_win import bfg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s1,
	input  pos_flags_t        flags_s1,
	input  logic [CH_W-1:0]   top_red,
	input  logic [CH_W-1:0]   mid_red,
	input  logic [CH_W-1:0]   bot_red,
	input  rgb_t              center_new,
	output logic              out_valid,
	output logic [CH_W-1:0]   out_red,
	output logic [CH_W-1:0]   out_green,
	output logic [CH_W-1:0]   out_blue,
	output logic              frame_last
);

	logic [CH_W-1:0] win_q [9];
	logic [CH_W-1:0] wn [9];
	rgb_t            center_q;

	logic             valid_s2;
	pos_flags_t       flags_s2;
	logic [SUM_W-1:0] sum_s2;
	rgb_t             prev_s2;

	logic [SUM_W-1:0]  row0;
	logic [SUM_W-1:0]  row1;
	logic [SUM_W-1:0]  row2;
	logic [PROD_W-1:0] prod;
	logic [CH_W-1:0]   gray;

	logic              out_valid_q;
	logic [CH_W-1:0]   out_red_q;
	logic [CH_W-1:0]   out_green_q;
	logic [CH_W-1:0]   out_blue_q;
	logic              frame_last_q;

	// Window shifts left by one column; the new column enters on the right.
	always_comb begin
		wn[0] = win_q[1];
		wn[1] = win_q[2];
		wn[2] = top_red;
		wn[3] = win_q[4];
		wn[4] = win_q[5];
		wn[5] = mid_red;
		wn[6] = win_q[7];
		wn[7] = win_q[8];
		wn[8] = bot_red;
		row0 = SUM_W'(wn[0]) + SUM_W'(wn[1]) + SUM_W'(wn[2]);
		row1 = SUM_W'(wn[3]) + SUM_W'(wn[4]) + SUM_W'(wn[5]);
		row2 = SUM_W'(wn[6]) + SUM_W'(wn[7]) + SUM_W'(wn[8]);
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= wn[k];
			end
			center_q <= center_new;
			flags_s2 <= flags_s1;
			sum_s2   <= row0 + row1 + row2;
			prev_s2  <= center_q;
		end
	end

	always_comb begin
		prod = PROD_W'(sum_s2) * PROD_W'(DIV9_RECIP);
		gray = prod[DIV9_SHIFT +: CH_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && flags_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			if (flags_s2.interior) begin
				out_red_q   <= gray;
				out_green_q <= gray;
				out_blue_q  <= gray;
			end else begin
				out_red_q   <= prev_s2[2*CH_W +: CH_W];
				out_green_q <= prev_s2[CH_W +: CH_W];
				out_blue_q  <= prev_s2[0 +: CH_W];
			end
			frame_last_q <= flags_s2.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_red_q;
	assign out_green  = out_green_q;
	assign out_blue   = out_blue_q;
	assign frame_last = frame_last_q;

endmodule

// File: rtl/box_filter_3x3_gray.sv
// The pixel that retires a result (one row and one pixel later) passes stage 1
// and stage 2, and the result is then registered on the output register.
// Throughput: one beat per clock; the input stalls only while a finished
// result waits on a stalled output, as the whole pipeline freezes then.
// Reset (arst_n low, asynchronous) clears the position counters and the stage
// valids and loads 640 x 480; the line memories keep their contents.
module box_filter_3x3_gray import bfg_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CH_W-1:0]      pixel_red,
	input  logic [CH_W-1:0]      pixel_green,
	input  logic [CH_W-1:0]      pixel_blue,
	input  logic                 flush_pad,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue,
	output logic                 frame_last,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	// The pipeline moves as one: it advances unless a result is held on the
	// output by a stalled receiver.
	logic en;
	logic accept;

	logic [CW-1:0] col;
	pos_flags_t    flags;

	// Stage 1: the line memories have returned column col_s1 of the two
	// previous rows; this stage writes them back shifted down by one row.
	logic          valid_s1;
	logic [CW-1:0] col_s1;
	rgb_t          pix_s1;
	pos_flags_t    flags_s1;

	// Forwarding: when the next beat reads the same column that stage 1
	// writes in the same cycle (a one-pixel-wide frame, or a new frame that
	// restarts at the column just written), the memory returns stale data,
	// so the values being written are kept and used instead.
	logic fwd_s1;
	rgb_t fwd_a_s1;
	rgb_t fwd_b_s1;

	rgb_t rd_a;
	rgb_t rd_b;
	rgb_t a_val;
	rgb_t b_val;
	rgb_t pix_in;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	// A flush beat enters the window as a black pixel.
	assign pix_in = flush_pad ? '0 : {pixel_red, pixel_green, pixel_blue};

	assign a_val = fwd_s1 ? fwd_a_s1 : rd_a;
	assign b_val = fwd_s1 ? fwd_b_s1 : rd_b;

	bfg_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.adv      (accept),
		.col      (col),
		.flags    (flags)
	);

	// Line memory A holds the previous row, B the row before that.
	bfg_ram #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(PIX_W)
	) u_line_a (
		.clk  (clk),
		.we   (en && valid_s1),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(col),
		.rdata(rd_a)
	);

	bfg_ram #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(PIX_W)
	) u_line_b (
		.clk  (clk),
		.we   (en && valid_s1),
		.waddr(col_s1),
		.wdata(a_val),
		.re   (accept),
		.raddr(col),
		.rdata(rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col;
			pix_s1   <= pix_in;
			flags_s1 <= flags;
			fwd_s1   <= valid_s1 && (col == col_s1);
			fwd_a_s1 <= pix_s1;
			fwd_b_s1 <= a_val;
		end
	end

	// Stage 2 and the output register: window, nine-way sum, divide by nine.
	bfg_win u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s1  (valid_s1),
		.flags_s1  (flags_s1),
		.top_red   (b_val[2*CH_W +: CH_W]),
		.mid_red   (a_val[2*CH_W +: CH_W]),
		.bot_red   (pix_s1[2*CH_W +: CH_W]),
		.center_new(a_val),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_last(frame_last)
	);

endmodule

// File: rtl/bfg_checker.sv
module bfg_checker import bfg_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [CH_W-1:0]      pixel_red,
	input logic [CH_W-1:0]      pixel_green,
	input logic [CH_W-1:0]      pixel_blue,
	input logic                 flush_pad,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CH_W-1:0]      out_red,
	input logic [CH_W-1:0]      out_green,
	input logic [CH_W-1:0]      out_blue,
	input logic                 frame_last
);

	// A stalled input beat stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pixel_red) &&
		$stable(pixel_green) && $stable(pixel_blue) && $stable(flush_pad))
	else $error("input beat changed while stalled");

	// A held result keeps its beat intact.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) &&
		$stable(out_green) && $stable(out_blue) && $stable(frame_last))
	else $error("output beat changed while stalled");

	// While a result is held, the input side must be frozen too.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
	else $error("input accepted while output is held");

	// The block never stalls its source unless the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
	else $error("input stalled with free output");

	// A new result can only come out of a pipeline advance, never out of a frozen pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_stall))
	else $error("result appeared while pipeline was frozen");

endmodule

bind box_filter_3x3_gray bfg_checker u_bfg_checker (.*);

// File: tb/tb_box_filter_3x3_gray.sv
`timescale 1ns / 1ps

module tb_box_filter_3x3_gray;
	import bfg_pkg::*;

	// Line memory depth of the instance under test.
	localparam int LINE_DEPTH = 1024;
	// A 3x3 window holds nine reds; their mean is the gray level.
	localparam int WINDOW_TAPS = 9;
	// Percentage of cycles in which either side idles while idling is on.
	localparam int IDLE_PCT = 35;
	// Cycles allowed after the last result before touching a register.
	localparam int SETTLE_CYCLES = 8;
	// Length of the deliberate output hold-off.
	localparam int HOLD_CYCLES = 80;
	// Cycles in a row with no beat on either side before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Least number of beats sent in the random frame loop.
	localparam int RANDOM_BEATS = 200;
	// Beats sent at the geometry loaded by reset: one row and a few pixels.
	localparam int RESET_GEOMETRY_BEATS = RST_WIDTH + 5;
	// Beats sent at the saturated width: one full row and a few pixels.
	localparam int SAT_BEATS = LINE_DEPTH + 8;
	// Beat of the saturated run before which the sender waits for the output.
	localparam int SAT_PAUSE = LINE_DEPTH + 4;
	// Height of the one-column frame that runs under the long output hold.
	localparam int TALL_HEIGHT = 40;
	// Only the first few mismatches are printed; the rest are only counted.
	localparam int MAX_REPORTS = 10;
	// Register index that maps to no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum int {
		FRAME_FULL,     // pixels followed by the complete flush tail
		FRAME_NO_FLUSH, // pixels only; the next frame doubles as the flush
		FRAME_CUT,      // a random prefix, then often a register write that restarts
		FRAME_NOISY     // flush beats scattered among the pixels
	} frame_kind_t;

	// Tracks the filter state beat by beat and keeps the pixels that the
	// block still owes, oldest first.
	class box_mean_scoreboard;
		typedef struct {
			logic [CH_W-1:0] red;
			logic [CH_W-1:0] green;
			logic [CH_W-1:0] blue;
			logic            last;
		} out_pixel_t;

		logic [FW_W-1:0] width_reg;
		logic [FH_W-1:0] height_reg;
		rgb_t            row_prev[LINE_DEPTH];
		rgb_t            row_older[LINE_DEPTH];
		logic [CH_W-1:0] win_red[WINDOW_TAPS];
		rgb_t            center;
		int              col;
		int              row;
		out_pixel_t      awaited[$];
		int unsigned     failures;

		function new();
			width_reg = FW_W'(RST_WIDTH);
			height_reg = RST_HEIGHT;
			foreach (row_prev[i]) begin
				row_prev[i] = '0;
				row_older[i] = '0;
			end
			foreach (win_red[i])
				win_red[i] = '0;
			center = '0;
			col = 0;
			row = 0;
			failures = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_DEPTH)
				return LINE_DEPTH;
			return int'(width_reg);
		endfunction

		function int eff_height();
			return (height_reg == 0) ? 1 : int'(height_reg);
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
			if (idx == CFG_FRAME_WIDTH) begin
				width_reg = value[FW_W-1:0];
				col = 0;
				row = 0;
			end else if (idx == CFG_FRAME_HEIGHT) begin
				height_reg = value[FH_W-1:0];
				col = 0;
				row = 0;
			end
		endfunction

		function void fail(input string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void note_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
				input logic [CH_W-1:0] blue, input logic pad);
			int         w;
			int         h;
			int         r;
			int         c;
			int         orow;
			int         ocol;
			int         sum;
			bit         emit;
			rgb_t       pix;
			rgb_t       prev;
			out_pixel_t res;
			w = eff_width();
			h = eff_height();
			if (col >= w || row > h + 1) begin
				col = 0;
				row = 0;
			end
			r = row;
			c = col;
			pix = pad ? '0 : {red, green, blue};
			prev = center;

			// Slide the window one column and bring in the new column of reds.
			for (int k = 0; k < 3; k++) begin
				win_red[3 * k] = win_red[3 * k + 1];
				win_red[3 * k + 1] = win_red[3 * k + 2];
			end
			win_red[2] = row_older[c][PIX_W-1 -: CH_W];
			win_red[5] = row_prev[c][PIX_W-1 -: CH_W];
			win_red[8] = pix[PIX_W-1 -: CH_W];

			center = row_prev[c];
			row_older[c] = row_prev[c];
			row_prev[c] = pix;

			// The retired pixel sits one row and one column back.
			if (c >= 1) begin
				orow = r - 1;
				ocol = c - 1;
			end else begin
				orow = r - 2;
				ocol = w - 1;
			end
			// The window is primed once the stream is past the first pixel of row 1.
			emit = (r >= 2 || (r == 1 && c >= 1)) && orow >= 0 && orow < h;

			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r * w + c >= w * h + w + 1) begin
				row = 0;
				col = 0;
			end else begin
				row = r;
				col = c;
			end

			if (!emit)
				return;

			if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2) begin
				sum = 0;
				foreach (win_red[k])
					sum += win_red[k];
				sum = sum / WINDOW_TAPS;
				res.red = CH_W'(sum);
				res.green = CH_W'(sum);
				res.blue = CH_W'(sum);
			end else begin
				res.red = prev[PIX_W-1 -: CH_W];
				res.green = prev[2*CH_W-1 -: CH_W];
				res.blue = prev[CH_W-1:0];
			end
			res.last = (orow == h - 1 && ocol == w - 1);
			awaited.push_back(res);
		endfunction

		function void check_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
				input logic [CH_W-1:0] blue, input logic last);
			out_pixel_t want;
			if (awaited.size() == 0) begin
				fail($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b",
					red, green, blue, last));
				return;
			end
			want = awaited.pop_front();
			if (want.red !== red || want.green !== green || want.blue !== blue ||
					want.last !== last)
				fail($sformatf("expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
					want.red, want.green, want.blue, want.last, red, green, blue, last));
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void close_out();
			if (awaited.size() != 0)
				fail($sformatf("%0d pixels never came out", awaited.size()));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CH_W-1:0]      pixel_red = '0;
	logic [CH_W-1:0]      pixel_green = '0;
	logic [CH_W-1:0]      pixel_blue = '0;
	logic                 flush_pad = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic                 frame_last;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Traffic shaping knobs, set by the main sequence.
	bit                   in_steady = 1'b0;
	bit                   out_steady = 1'b0;
	bit                   hold_req = 1'b0;

	int unsigned          beats_sent = 0;
	int unsigned          stuck_cycles = 0;
	box_mean_scoreboard   sb;

	box_filter_3x3_gray #(
		.MAX_WIDTH(LINE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_red(pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue(pixel_blue),
		.flush_pad(flush_pad),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_last(frame_last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Both beat directions are observed at the rising edge, where every input
	// is stable (inputs only move at the falling edge). An accepted input beat
	// updates the prediction; an accepted output beat is compared against the
	// oldest predicted pixel. The watchdog lives here too.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (in_valid && !in_stall)
				sb.note_pixel(pixel_red, pixel_green, pixel_blue, flush_pad);
			if (out_valid && !out_stall)
				sb.check_pixel(out_red, out_green, out_blue, frame_last);
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Output side. Normally stalls at random; on request it holds off for a
	// long stretch so the pipeline fills and the input stall comes up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= !out_steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic logic [CH_W-1:0] pick_channel();
		if ($urandom_range(99) < 15)
			return $urandom_range(1) ? {CH_W{1'b1}} : {CH_W{1'b0}};
		return CH_W'($urandom);
	endfunction

	// Offers one beat and returns at the rising edge that accepts it. Random
	// gaps come before the beat unless the sender is running steady.
	task automatic send_beat(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
			input logic [CH_W-1:0] blue, input logic pad);
		@(negedge clk);
		if (!in_steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		pixel_red <= red;
		pixel_green <= green;
		pixel_blue <= blue;
		flush_pad <= pad;
		do begin
			@(posedge clk);
		end while (in_stall);
		beats_sent++;
	endtask

	task automatic send_random(input logic pad);
		send_beat(pick_channel(), pick_channel(), pick_channel(), pad);
	endtask

	task automatic rest_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		rest_sender();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Beats that retire nothing may still be in the pipeline when the last
	// pixel comes out, so give them time before a register changes.
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
		write_reg(CFG_FRAME_WIDTH, w_val);
		write_reg(CFG_FRAME_HEIGHT, h_val);
	endtask

	// Mostly small frames so that many frame boundaries and border cases go
	// by; now and then a zero register or stray bits above the width field.
	task automatic random_geometry();
		logic [CFG_W-1:0] wv;
		logic [CFG_W-1:0] hv;
		int               roll;
		roll = $urandom_range(99);
		if (roll < 70)
			wv = CFG_W'($urandom_range(12, 1));
		else if (roll < 82)
			wv = CFG_W'($urandom_range(64, 13));
		else if (roll < 92)
			wv = '0;
		else
			wv = CFG_W'($urandom_range(3, 1) | ($urandom_range(3, 1) << FW_W));
		roll = $urandom_range(99);
		if (roll < 75)
			hv = CFG_W'($urandom_range(8, 1));
		else if (roll < 88)
			hv = '0;
		else
			hv = CFG_W'($urandom_range(24, 9));
		set_geometry(wv, hv);
	endtask

	// Sends one frame at the current geometry. pause_at names a beat before
	// which the sender stops until every owed pixel has come out.
	task automatic send_frame(input frame_kind_t kind, input int pause_at);
		int w;
		int n;
		int total;
		w = sb.eff_width();
		n = w * sb.eff_height();
		total = n + w + 1;
		if (kind == FRAME_NO_FLUSH)
			total = n;
		else if (kind == FRAME_CUT)
			total = $urandom_range(total - 1, 1);
		for (int i = 0; i < total; i++) begin
			if (i == pause_at)
				wait_drained();
			if (kind == FRAME_NOISY)
				send_random($urandom_range(99) < 20);
			else if (i < n)
				send_random(1'b0);
			else
				send_random($urandom_range(9) != 0); // now and then a real pixel in the tail
		end
	endtask

	initial begin
		frame_kind_t kind;
		frame_kind_t prev_kind;
		int          frame_no;
		int unsigned loop_start;
		bit          spare_done;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Run on the geometry loaded by reset: the first row plus a few pixels
		// of the next shows the reset width through where results start.
		for (int i = 0; i < RESET_GEOMETRY_BEATS; i++)
			send_random(1'b0);
		wait_idle();

		// Smallest frame with an interior pixel. All reds at full scale give
		// the largest possible sum; the tail carries two flush beats with data
		// and one real pixel in a flush slot.
		set_geometry(3, 3);
		for (int i = 0; i < 9; i++)
			send_beat(8'hFF, i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, 1'b0);
		send_beat(8'h5A, 8'hA5, 8'h3C, 1'b1);
		send_beat(8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_beat(8'h00, 8'h00, 8'h00, 1'b1);
		send_beat(8'h81, 8'h42, 8'h24, 1'b0);
		// Same geometry, ramped reds, and a flush beat in a pixel slot, which
		// enters the window as a black pixel.
		for (int i = 0; i < 9; i++)
			send_beat(CH_W'(i * 28), CH_W'(~(i * 28)), 8'h80, i == 0);
		for (int i = 0; i < 4; i++)
			send_random(1'b1);
		wait_idle();

		// Width written above the line memory saturates to its depth; one row
		// and a few pixels show where results start. Both sides run without
		// gaps, and once results flow the sender waits for the output to
		// catch up completely.
		set_geometry(2047, 3);
		in_steady = 1'b1;
		out_steady = 1'b1;
		for (int i = 0; i < SAT_BEATS; i++) begin
			if (i == SAT_PAUSE)
				wait_drained();
			send_random(1'b0);
		end
		in_steady = 1'b0;
		out_steady = 1'b0;
		wait_idle();

		// One column of a tall frame; zero width reads as one. The output
		// holds off for a long stretch while the sender keeps offering beats.
		set_geometry(0, TALL_HEIGHT);
		in_steady = 1'b1;
		hold_req = 1'b1;
		send_frame(FRAME_FULL, -1);
		in_steady = 1'b0;
		wait_idle();

		// A single pixel frame.
		set_geometry(1, 1);
		send_frame(FRAME_FULL, -1);

		// Random frames. Register writes only follow a drained pipeline; a frame
		// without its flush tail runs straight into the next one instead.
		loop_start = beats_sent;
		frame_no = 0;
		prev_kind = FRAME_FULL;
		spare_done = 1'b0;
		while (beats_sent - loop_start < RANDOM_BEATS) begin
			if (prev_kind != FRAME_NO_FLUSH && $urandom_range(99) < 70) begin
				wait_idle();
				random_geometry();
			end
			if (frame_no == 1) begin
				kind = FRAME_CUT;
			end else begin
				case ($urandom_range(9))
					0: kind = FRAME_NO_FLUSH;
					1: kind = FRAME_CUT;
					2: kind = FRAME_NOISY;
					default: kind = FRAME_FULL;
				endcase
			end
			send_frame(kind, -1);
			// A write to an unmapped index must leave the stream position alone,
			// so try it once in the middle of an abandoned frame.
			if (kind == FRAME_CUT && !spare_done) begin
				wait_idle();
				write_reg(CFG_SPARE, CFG_W'($urandom));
				spare_done = 1'b1;
			end
			prev_kind = kind;
			frame_no++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: box_filter_3x3_gray.f
rtl/bfg_pkg.sv
rtl/bfg_ram.sv
rtl/bfg_pos.sv
rtl/bfg_win.sv
rtl/box_filter_3x3_gray.sv
rtl/bfg_checker.sv
tb/tb_box_filter_3x3_gray.sv
